>>> rtl/core/rc_pwm_pulse_capture_normalizer_defines.svh
// Assertion macros shared by the capture normalizer RTL
`ifndef RC_PWM_PULSE_CAPTURE_NORMALIZER_DEFINES_SVH
`define RC_PWM_PULSE_CAPTURE_NORMALIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RCPCN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RCPCN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rcpcn_pkg.sv
// Shared types and constants of the RC PWM capture normalizer
`timescale 1ns / 1ps
`default_nettype none
package rcpcn_pkg;

    localparam int RCPCN_NUM_CHANNELS = 6;
    localparam int RCPCN_CH_W         = 3;
    localparam int RCPCN_TIME_W       = 16;
    localparam int RCPCN_CFG_ADDR_W   = 2;
    localparam int RCPCN_DIV_STEPS    = 16;
    localparam int RCPCN_DIV_CNT_W    = 5;

    localparam logic [15:0] RCPCN_FULL_SCALE = 16'hFFFF;
    localparam logic [15:0] RCPCN_MID_SCALE  = 16'h8000;

    localparam logic [15:0] RCPCN_CAL_MIN_RST    = 16'd1000;
    localparam logic [15:0] RCPCN_CAL_MAX_RST    = 16'd2000;
    localparam logic [15:0] RCPCN_ACCEPT_MIN_RST = 16'd800;
    localparam logic [15:0] RCPCN_ACCEPT_MAX_RST = 16'd2200;

    // Configuration register indexes
    typedef enum logic [RCPCN_CFG_ADDR_W-1:0] {
        CFG_CAL_MIN    = 2'd0,
        CFG_CAL_MAX    = 2'd1,
        CFG_ACCEPT_MIN = 2'd2,
        CFG_ACCEPT_MAX = 2'd3
    } t_cfg_addr;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCALE,
        S_DIV,
        S_PUSH
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

>>> rtl/core/rcpcn_div.sv
// Iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rcpcn_div
    import rcpcn_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,   // quotient must fit in 16 bits
    input  wire logic [15:0] i_divisor,
    output t_div_stat        o_stat,
    output logic      [15:0] o_quot
);

    logic [15:0]                r_rem, n_rem;
    logic [15:0]                r_quo, n_quo;
    logic [15:0]                r_div;
    logic [RCPCN_DIV_CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [16:0] rem_sh;
    logic [16:0] rem_sub;
    logic        ge;

    // One shift-compare-subtract step
    always_comb begin
        rem_sh  = {r_rem, r_quo[15]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = (rem_sh >= {1'b0, r_div});
        n_rem   = ge ? rem_sub[15:0] : rem_sh[15:0];
        n_quo   = {r_quo[14:0], ge};
    end

    // Control: load on start, count down the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= RCPCN_DIV_CNT_W'(RCPCN_DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == RCPCN_DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: upper half seeds the remainder, lower half shifts through
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= i_dividend[31:16];
            r_quo <= i_dividend[15:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule
`default_nettype wire

>>> rtl/core/rc_pwm_pulse_capture_normalizer.sv
// Top level: RC PWM capture decoder with per-channel state and scaling
//
// Each input word is one timer capture (channel, 16-bit timestamp). Channels toggle between
// rising and falling edges; a rise updates the period, a fall measures the width and stores it
// if it lies within the acceptance limits. Every event on a valid channel yields one output word
// with the stored width, the period and the width scaled to 0..65535 and -32768..32767 against
// the calibration limits. Captures on channels at or above NUM_CHANNELS are taken and dropped.
// An event passes from acceptance through the evaluate and scale states to push, with the
// shared 16-step restoring divider run in between unless the width is clamped or the limits
// are equal; the next word is taken once the sequencer is back in idle. The output register
// lets a finished word wait while the next capture is taken; push waits while it stays full.
// Configuration must be written only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_pwm_pulse_capture_normalizer_defines.svh"
module rc_pwm_pulse_capture_normalizer
    import rcpcn_pkg::*;
#(
    parameter int NUM_CHANNELS = RCPCN_NUM_CHANNELS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // capture input
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [23:0]                 s_axis_tdata,  // channel[2:0], capture_time[18:3]
    // result output
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [71:0]                      m_axis_tdata,  // channel_out[2:0],
                                                            // pulse_ticks[18:3],
                                                            // period_ticks[34:19],
                                                            // pulse_accepted[35],
                                                            // level_unsigned[51:36],
                                                            // level_signed[67:52]
    output logic [0:0]                       m_axis_tuser,  // was_rising[0]
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [RCPCN_CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [15:0]                 i_cfg_wdata
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Configuration registers
    logic [15:0] r_cal_min, r_cal_max, r_acc_min, r_acc_max;

    // Per-channel state
    logic              r_phase  [NUM_CHANNELS];
    logic [15:0]       r_rise   [NUM_CHANNELS];
    logic [15:0]       r_pwidth [NUM_CHANNELS];
    logic [15:0]       r_period [NUM_CHANNELS];

    // Work registers
    t_state                r_state, n_state;
    logic [RCPCN_CH_W-1:0] r_ch;
    logic [15:0]           r_time;
    logic                  r_rising;
    logic                  r_accept;
    logic [15:0]           r_pulse;
    logic [15:0]           r_per;
    logic [15:0]           r_lvl;

    // Output register
    logic                  r_out_valid;
    logic [RCPCN_CH_W-1:0] r_out_ch;
    logic                  r_out_rising;
    logic                  r_out_accept;
    logic [15:0]           r_out_pulse;
    logic [15:0]           r_out_per;
    logic [15:0]           r_out_lvl;

    // Shared divider
    t_div_stat   div_stat;
    logic        div_start;
    logic [15:0] div_quot;
    logic [15:0] scale_off;
    logic [15:0] scale_span;
    logic [31:0] scale_num;

    // Decode and helpers
    logic [RCPCN_CH_W-1:0] in_ch;
    logic [15:0]           in_time;
    logic                  in_take;
    logic                  in_ch_ok;
    logic [CH_IDX_W-1:0]   idx;
    logic [15:0]           diff;
    logic                  diff_ok;
    logic                  lvl_lo;
    logic                  lvl_hi;
    logic                  lvl_eq;
    logic                  out_free;

    assign in_ch    = s_axis_tdata[2:0];
    assign in_time  = s_axis_tdata[18:3];
    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign in_ch_ok = (5'(in_ch) < 5'(NUM_CHANNELS));
    assign idx      = CH_IDX_W'(r_ch);
    assign diff     = r_time - r_rise[idx];
    assign diff_ok  = (diff >= r_acc_min) && (diff <= r_acc_max);
    assign lvl_lo   = (r_pulse < r_cal_min);
    assign lvl_hi   = (r_pulse > r_cal_max);
    assign lvl_eq   = (r_cal_max == r_cal_min);
    assign out_free = !r_out_valid || m_axis_tready;

    // Scaling operands: (w - min) * 65535 / (max - min)
    assign scale_off  = r_pulse - r_cal_min;
    assign scale_span = r_cal_max - r_cal_min;
    assign scale_num  = {scale_off, 16'h0000} - {16'h0000, scale_off};

    rcpcn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (scale_num),
        .i_divisor  (scale_span),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take && in_ch_ok) n_state = S_EVAL;
            S_EVAL:  n_state = S_SCALE;
            S_SCALE: n_state = (lvl_lo || lvl_hi || lvl_eq) ? S_PUSH : S_DIV;
            S_DIV:   if (div_stat.done) n_state = S_PUSH;
            S_PUSH:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        unique case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_SCALE: div_start = !(lvl_lo || lvl_hi || lvl_eq);
            S_EVAL, S_DIV, S_PUSH: ;
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= r_state == n_state ? r_state : n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_min <= RCPCN_CAL_MIN_RST;
            r_cal_max <= RCPCN_CAL_MAX_RST;
            r_acc_min <= RCPCN_ACCEPT_MIN_RST;
            r_acc_max <= RCPCN_ACCEPT_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_CAL_MIN:    r_cal_min <= i_cfg_wdata;
                CFG_CAL_MAX:    r_cal_max <= i_cfg_wdata;
                CFG_ACCEPT_MIN: r_acc_min <= i_cfg_wdata;
                CFG_ACCEPT_MAX: r_acc_max <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Channel state update on the evaluate step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_phase[i]  <= 1'b0;
                r_rise[i]   <= '0;
                r_pwidth[i] <= '0;
                r_period[i] <= '0;
            end
        end else if (r_state == S_EVAL) begin
            if (!r_phase[idx]) begin
                r_period[idx] <= diff;
                r_rise[idx]   <= r_time;
                r_phase[idx]  <= 1'b1;
            end else begin
                r_phase[idx] <= 1'b0;
                if (diff_ok) begin
                    r_pwidth[idx] <= diff;
                end
            end
        end
    end

    // Work registers: capture, evaluate, scale
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch   <= in_ch;
            r_time <= in_time;
        end
        if (r_state == S_EVAL) begin
            r_rising <= !r_phase[idx];
            r_accept <= r_phase[idx] && diff_ok;
            r_pulse  <= (r_phase[idx] && diff_ok) ? diff : r_pwidth[idx];
            r_per    <= r_phase[idx] ? r_period[idx] : diff;
        end
        if (r_state == S_SCALE) begin
            priority if (lvl_lo) r_lvl <= '0;
            else if (lvl_hi)     r_lvl <= RCPCN_FULL_SCALE;
            else if (lvl_eq)     r_lvl <= RCPCN_MID_SCALE;
            else                 r_lvl <= r_lvl;
        end
        if (div_stat.done) begin
            r_lvl <= div_quot;
        end
    end

    // Output register: drop on take, load on push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && out_free) begin
            r_out_ch     <= r_ch;
            r_out_rising <= r_rising;
            r_out_accept <= r_accept;
            r_out_pulse  <= r_pulse;
            r_out_per    <= r_per;
            r_out_lvl    <= r_lvl;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_rising;
    assign m_axis_tdata  = {4'b0000,
                            r_out_lvl ^ RCPCN_MID_SCALE,
                            r_out_lvl,
                            r_out_accept,
                            r_out_per,
                            r_out_pulse,
                            r_out_ch};

    // Checks on sequencer and divider cooperation
    `RCPCN_ASSERT_NOW(a_ready_div_idle, s_axis_tready, !div_stat.busy,
        "input ready while divider busy")
    `RCPCN_ASSERT_NOW(a_done_in_div, div_stat.done, r_state == S_DIV,
        "divider done outside division state")
    `RCPCN_ASSERT_NEXT(a_take_to_eval, in_take && in_ch_ok, r_state == S_EVAL,
        "valid capture did not start evaluation")
    `RCPCN_ASSERT_NOW(a_clamp_low, r_state == S_PUSH && lvl_lo, r_lvl == '0,
        "width below calibration minimum not clamped to zero")

endmodule
`default_nettype wire

>>> test/rc_pwm_capture_checker.sv
// Result predictor and scoreboard for the RC PWM capture normalizer testbench
`timescale 1ns / 1ps
module rc_pwm_capture_checker
    import rcpcn_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tready,
    input  wire logic [23:0]                 s_axis_tdata,  // channel[2:0], capture_time[18:3]
    input  wire logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic [71:0]                 m_axis_tdata,  // channel_out[2:0],
                                                            // pulse_ticks[18:3],
                                                            // period_ticks[34:19],
                                                            // pulse_accepted[35],
                                                            // level_unsigned[51:36],
                                                            // level_signed[67:52]
    input  wire logic [0:0]                  m_axis_tuser,  // was_rising[0]
    input  wire logic                        i_cfg_we,
    input  wire logic [RCPCN_CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [15:0]                 i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic [2:0]  ch;
        logic        rising;
        logic [15:0] pulse;
        logic [15:0] period;
        logic        accepted;
        logic [15:0] level_u;
        logic [15:0] level_s;
    } t_pulse_report;

    // Shadow of the calibration and acceptance limits
    logic [15:0] cal_min;
    logic [15:0] cal_max;
    logic [15:0] acc_min;
    logic [15:0] acc_max;

    // Per-channel edge tracking
    logic        awaiting_fall [RCPCN_NUM_CHANNELS];
    logic [15:0] rise_stamp    [RCPCN_NUM_CHANNELS];
    logic [15:0] width_held    [RCPCN_NUM_CHANNELS];
    logic [15:0] period_held   [RCPCN_NUM_CHANNELS];

    t_pulse_report report_q [$];
    int            mismatches = 0;
    int            pending_n  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;

    // Map a stored width onto 0..65535 against the calibration limits
    function automatic logic [15:0] level_of(input logic [15:0] w);
        logic [15:0] diff;
        logic [15:0] span;
        logic [31:0] num;
        logic [31:0] quo;
        diff = w - cal_min;
        span = cal_max - cal_min;
        num  = {16'd0, diff} * 32'd65535;
        quo  = (span != 16'd0) ? num / {16'd0, span} : 32'd0;
        if (w < cal_min)
            return 16'd0;
        if (w > cal_max)
            return RCPCN_FULL_SCALE;
        if (cal_max > cal_min)
            return quo[15:0];
        return RCPCN_MID_SCALE;
    endfunction

    // Advance one channel by one capture and build the word it reports
    function automatic t_pulse_report decode_capture(input logic [2:0] ch,
                                                     input logic [15:0] ts);
        t_pulse_report r;
        logic [15:0]   gap;
        gap        = ts - rise_stamp[ch];
        r.accepted = 1'b0;
        if (!awaiting_fall[ch]) begin
            r.rising          = 1'b1;
            period_held[ch]   = gap;
            rise_stamp[ch]    = ts;
            awaiting_fall[ch] = 1'b1;
        end else begin
            r.rising          = 1'b0;
            awaiting_fall[ch] = 1'b0;
            if (gap >= acc_min && gap <= acc_max) begin
                width_held[ch] = gap;
                r.accepted     = 1'b1;
            end
        end
        r.ch      = ch;
        r.pulse   = width_held[ch];
        r.period  = period_held[ch];
        r.level_u = level_of(width_held[ch]);
        r.level_s = r.level_u - RCPCN_MID_SCALE;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, want, got);
        end
    endtask

    // Track config writes, queue predictions and compare result words
    always @(posedge i_clk) begin : watch
        t_pulse_report got;
        t_pulse_report want;
        if (!i_rst_n) begin
            cal_min = RCPCN_CAL_MIN_RST;
            cal_max = RCPCN_CAL_MAX_RST;
            acc_min = RCPCN_ACCEPT_MIN_RST;
            acc_max = RCPCN_ACCEPT_MAX_RST;
            for (int i = 0; i < RCPCN_NUM_CHANNELS; i++) begin
                awaiting_fall[i] = 1'b0;
                rise_stamp[i]    = 16'd0;
                width_held[i]    = 16'd0;
                period_held[i]   = 16'd0;
            end
            report_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CAL_MIN:    cal_min = i_cfg_wdata;
                    CFG_CAL_MAX:    cal_max = i_cfg_wdata;
                    CFG_ACCEPT_MIN: acc_min = i_cfg_wdata;
                    CFG_ACCEPT_MAX: acc_max = i_cfg_wdata;
                    default: ;
                endcase
            end
            // Drop captures on channels past the last one
            if (s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] < RCPCN_NUM_CHANNELS)
                report_q.push_back(decode_capture(s_axis_tdata[2:0], s_axis_tdata[18:3]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.ch       = m_axis_tdata[2:0];
                got.pulse    = m_axis_tdata[18:3];
                got.period   = m_axis_tdata[34:19];
                got.accepted = m_axis_tdata[35];
                got.level_u  = m_axis_tdata[51:36];
                got.level_s  = m_axis_tdata[67:52];
                got.rising   = m_axis_tuser[0];
                if (report_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with none expected, channel %0d",
                                 $realtime, got.ch);
                end else begin
                    want = report_q.pop_front();
                    check_field("channel_out", 16'(want.ch), 16'(got.ch));
                    check_field("was_rising", 16'(want.rising), 16'(got.rising));
                    check_field("pulse_ticks", want.pulse, got.pulse);
                    check_field("period_ticks", want.period, got.period);
                    check_field("pulse_accepted", 16'(want.accepted), 16'(got.accepted));
                    check_field("level_unsigned", want.level_u, got.level_u);
                    check_field("level_signed", want.level_s, got.level_s);
                end
            end
        end
        pending_n = report_q.size();
    end

endmodule

>>> test/rc_pwm_pulse_capture_normalizer_tb.sv
// Top of the RC PWM capture normalizer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module rc_pwm_pulse_capture_normalizer_tb;
    import rcpcn_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SEGMENT_WORDS = 92;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [23:0]                 s_axis_tdata  = '0;  // channel[2:0], capture_time[18:3]
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [71:0]                 m_axis_tdata;        // channel_out[2:0], pulse_ticks[18:3],
                                                      // period_ticks[34:19],
                                                      // pulse_accepted[35],
                                                      // level_unsigned[51:36],
                                                      // level_signed[67:52]
    logic [0:0]                  m_axis_tuser;        // was_rising[0]
    logic                        i_cfg_we      = 1'b0;
    logic [RCPCN_CFG_ADDR_W-1:0] i_cfg_addr    = CFG_CAL_MIN;
    logic [15:0]                 i_cfg_wdata   = '0;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int tx_idle_pct = 18;
    int rx_idle_pct = 55;

    // Current limits and per-channel edge view, used only to shape stimulus
    logic [15:0] cal_lo = RCPCN_CAL_MIN_RST;
    logic [15:0] cal_hi = RCPCN_CAL_MAX_RST;
    logic [15:0] acc_lo = RCPCN_ACCEPT_MIN_RST;
    logic [15:0] acc_hi = RCPCN_ACCEPT_MAX_RST;
    logic        high_now  [RCPCN_NUM_CHANNELS] = '{default: 1'b0};
    logic [15:0] last_rise [RCPCN_NUM_CHANNELS] = '{default: 16'd0};

    always #2 i_clk = ~i_clk;

    rc_pwm_pulse_capture_normalizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    rc_pwm_capture_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // Stall the result side at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one capture word, with an optional gap, and hold it until taken
    task automatic send_capture(input logic [2:0] ch, input logic [15:0] ts);
        @(negedge i_clk);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, ts, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        if (ch < RCPCN_NUM_CHANNELS) begin
            if (!high_now[ch])
                last_rise[ch] = ts;
            high_now[ch] = !high_now[ch];
        end
    endtask

    task automatic write_reg(input t_cfg_addr addr, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
    endtask

    // Load all four limits while the block sits idle
    task automatic set_limits(input logic [15:0] cmin, input logic [15:0] cmax,
                              input logic [15:0] amin, input logic [15:0] amax);
        write_reg(CFG_CAL_MIN, cmin);
        write_reg(CFG_CAL_MAX, cmax);
        write_reg(CFG_ACCEPT_MIN, amin);
        write_reg(CFG_ACCEPT_MAX, amax);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cal_lo = cmin;
        cal_hi = cmax;
        acc_lo = amin;
        acc_hi = amax;
    endtask

    // Wait for every expected word, then let a dropped capture finish too
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Pick a high time: mostly inside the acceptance window, often right on a limit
    function automatic logic [15:0] pick_width();
        int          r;
        logic [15:0] w;
        r = $urandom_range(99);
        if (r < 55) begin
            w = 16'($urandom_range(acc_hi, acc_lo));
        end else if (r < 80) begin
            case ($urandom_range(7))
                0:       w = acc_lo - 16'd1;
                1:       w = acc_lo;
                2:       w = acc_hi;
                3:       w = acc_hi + 16'd1;
                4:       w = cal_lo - 16'd1;
                5:       w = cal_lo;
                6:       w = cal_hi;
                default: w = cal_hi + 16'd1;
            endcase
        end else begin
            w = 16'($urandom);
        end
        return w;
    endfunction

    // Mostly well-formed rise/fall pairs, some broken timing and unused channels
    task automatic random_capture();
        int          pick;
        logic [2:0]  ch;
        logic [15:0] ts;
        pick = $urandom_range(99);
        ch   = 3'($urandom_range(RCPCN_NUM_CHANNELS - 1));
        if (pick < 8) begin
            ch = 3'($urandom_range(7, RCPCN_NUM_CHANNELS));
            ts = 16'($urandom);
        end else if (pick < 16) begin
            ts = 16'($urandom);
        end else if (!high_now[ch]) begin
            ts = last_rise[ch] + (($urandom_range(9) < 4) ? 16'($urandom)
                                                           : 16'($urandom_range(25000, 15000)));
        end else begin
            ts = last_rise[ch] + pick_width();
        end
        send_capture(ch, ts);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset limits
        send_capture(3'd0, 16'd0);       // same stamp as reset: period zero
        send_capture(3'd0, 16'd1500);    // mid-range width
        send_capture(3'd0, 16'hFFFF);    // full-scale period
        send_capture(3'd0, 16'd798);     // wrapped width just below accept minimum
        send_capture(3'd0, 16'd20000);
        send_capture(3'd0, 16'd20800);   // accept minimum, clamps to zero
        send_capture(3'd1, 16'd65000);
        send_capture(3'd1, 16'd1664);    // wrapped width at accept maximum, clamps high
        send_capture(3'd1, 16'd100);
        send_capture(3'd1, 16'd2301);    // one past accept maximum
        send_capture(3'd6, 16'hFFFF);    // unused channel
        send_capture(3'd7, 16'd0);       // unused channel
        send_capture(3'd5, 16'hFFFF);
        send_capture(3'd5, 16'd999);     // width equals calibration minimum
        send_capture(3'd4, 16'd0);
        send_capture(3'd4, 16'd2000);    // width equals calibration maximum
        send_capture(3'd2, 16'd4321);
        send_capture(3'd2, 16'd4321);    // zero width, rejected
        send_capture(3'd3, 16'd12345);
        send_capture(3'd3, 16'd14344);
        send_capture(3'd3, 16'hAAAA);
        send_capture(3'd3, 16'h5555);
        drain();

        // Random segments, each under its own limits; the idle pattern changes every two segments
        for (int seg = 0; seg < 6; seg++) begin
            tx_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 55 : 0;
            rx_idle_pct = (seg < 2) ? 55 : (seg < 4) ? 18 : 0;
            case (seg)
                0: set_limits(16'd1000, 16'd2000, 16'd900, 16'd2100);
                1: set_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                2: set_limits(16'd1500, 16'd1500, 16'd1000, 16'd2000);   // equal calibration
                3: set_limits(16'd2000, 16'd1000, 16'd2200, 16'd800);    // both inverted
                4: set_limits(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
                default: begin
                    set_limits(16'($urandom_range(1500, 500)), 16'd0, 16'd0, 16'd0);
                    set_limits(cal_lo, cal_lo + 16'($urandom_range(2000, 1)),
                               16'($urandom_range(1000, 0)), 16'd0);
                    set_limits(cal_lo, cal_hi, acc_lo, acc_lo + 16'($urandom_range(3000, 0)));
                end
            endcase
            repeat (SEGMENT_WORDS) random_capture();
            drain();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rcpcn_pkg.sv
rtl/core/rcpcn_div.sv
rtl/core/rc_pwm_pulse_capture_normalizer.sv
test/rc_pwm_capture_checker.sv
test/rc_pwm_pulse_capture_normalizer_tb.sv
